FILE: rtl/mrp_pkg.sv
// Shared types, constants and scale tables for the magnetometer conversion.
// Used by mrp_axis, mrp_temp and the top level; depends on nothing else.
package mrp_pkg;

  localparam int unsigned RawW     = 16;
  localparam int unsigned FieldW   = 25;
  localparam int unsigned TempW    = 19;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 4;

  // Field scaling: q = (|c| * ScaleTab[k] + RoundOffset) >> FracW
  localparam int unsigned FracW    = 24;
  localparam int unsigned ScaleW   = 36;
  localparam int unsigned MagW     = 16;
  localparam int unsigned ProdW    = MagW + ScaleW;
  localparam int unsigned QuotW    = ProdW - FracW;
  localparam int unsigned SatBit   = FieldW - 1;
  localparam longint      Divisor  = 375;
  localparam longint      RoundNum = 187;
  localparam logic [FracW-1:0] RoundOffset =
    FracW'(((RoundNum << FracW) + Divisor - 1) / Divisor);

  localparam logic signed [FieldW-1:0] FieldMax = {1'b0, {(FieldW-1){1'b1}}};
  localparam logic signed [FieldW-1:0] FieldMin = {1'b1, {(FieldW-1){1'b0}}};

  // Temperature: round((raw * 640 - TempBias) / 113), ties away from zero
  localparam int unsigned TempNumW  = 26;
  localparam int unsigned TempMagW  = TempNumW - 1;
  localparam int unsigned TempRecW  = 26;
  localparam int unsigned TempShift = 32;
  localparam int unsigned TempQW    = TempW - 1;
  localparam longint      TempDiv   = 113;
  localparam logic [TempNumW-1:0] TempBias  = TempNumW'(28872960);
  localparam logic [TempMagW-1:0] TempHalf  = TempMagW'(TempDiv / 2);
  localparam logic [TempRecW-1:0] TempRecip =
    TempRecW'(((longint'(1) << TempShift) + TempDiv - 1) / TempDiv);

  // Resolution codes with a fixed offset, and the alternate Hall setting code
  localparam logic [1:0] ResMidScale = 2'd2;
  localparam logic [1:0] ResQuarter  = 2'd3;
  localparam logic [3:0] HallAlt     = 4'd12;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGain     = 3'd0,
    CfgHall     = 3'd1,
    CfgResX     = 3'd2,
    CfgResY     = 3'd3,
    CfgResZ     = 3'd4,
    CfgTempComp = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic       is_z;
    logic       alt;
    logic [2:0] gain;
    logic [1:0] res;
    logic       comp;
  } axis_cfg_t;

  typedef logic [ScaleW-1:0] scale_tab_t [128];

  // Entry {is_z, alt, gain, res}: ceil(sens * gain_sixths * 16 * 2^res * 2^FracW / 375)
  function automatic scale_tab_t build_scale_tab();
    scale_tab_t tab;
    longint     sens;
    longint     g6;
    longint     m;
    for (int k = 0; k < 128; k++) begin
      case ((k >> 5) & 3)
        0: sens = 196;
        1: sens = 150;
        2: sens = 316;
        default: sens = 242;
      endcase
      case ((k >> 2) & 7)
        0: g6 = 30;
        1: g6 = 24;
        2: g6 = 18;
        3: g6 = 15;
        4: g6 = 12;
        5: g6 = 10;
        6: g6 = 8;
        default: g6 = 6;
      endcase
      m = (sens * g6 * 16) << (k & 3);
      tab[k] = ScaleW'(((m << FracW) + Divisor - 1) / Divisor);
    end
    return tab;
  endfunction

  localparam scale_tab_t ScaleTab = build_scale_tab();

endpackage

FILE: rtl/mrp_axis.sv
// One axis: centring, sensitivity scaling, rounding and saturation.
// Depends on mrp_pkg for the scale table and field limits.
module mrp_axis (
  input  logic [mrp_pkg::RawW-1:0]          raw_i,
  input  mrp_pkg::axis_cfg_t                cfg_i,
  output logic signed [mrp_pkg::FieldW-1:0] field_o
);
  import mrp_pkg::*;

  logic [RawW:0]     centred;
  logic [RawW:0]     centred_neg;
  logic              neg;
  logic [MagW-1:0]   mag;
  logic [ScaleW-1:0] scale;
  logic [ProdW-1:0]  prod;
  logic [QuotW-1:0]  quot;
  logic              over;

  always_comb begin
    if (cfg_i.comp || cfg_i.res == ResMidScale) begin
      centred = {1'b0, raw_i} - 17'd32768;
    end else if (cfg_i.res == ResQuarter) begin
      centred = {1'b0, raw_i} - 17'd16384;
    end else begin
      centred = {raw_i[RawW-1], raw_i};
    end
    centred_neg = ~centred + 17'd1;
    neg         = centred[RawW];
    mag         = neg ? centred_neg[MagW-1:0] : centred[MagW-1:0];
  end

  assign scale = ScaleTab[{cfg_i.is_z, cfg_i.alt, cfg_i.gain, cfg_i.res}];
  assign prod  = ProdW'(mag) * ProdW'(scale) + ProdW'(RoundOffset);
  assign quot  = prod[ProdW-1:FracW];
  assign over  = |quot[QuotW-1:SatBit];

  always_comb begin
    if (over) begin
      field_o = neg ? FieldMin : FieldMax;
    end else if (neg) begin
      field_o = FieldW'(0) - {1'b0, quot[SatBit-1:0]};
    end else begin
      field_o = {1'b0, quot[SatBit-1:0]};
    end
  end

endmodule

FILE: rtl/mrp_temp.sv
// Temperature conversion to 1/256 degree C, rounded by reciprocal multiply.
// Depends on mrp_pkg for the bias and reciprocal constants.
module mrp_temp (
  input  logic [mrp_pkg::RawW-1:0]         raw_i,
  output logic signed [mrp_pkg::TempW-1:0] temp_o
);
  import mrp_pkg::*;

  localparam int unsigned TProdW = TempMagW + TempRecW;

  logic [TempNumW-1:0] num;
  logic [TempNumW-1:0] num_neg;
  logic                neg;
  logic [TempMagW-1:0] mag;
  logic [TProdW-1:0]   prod;
  logic [TempQW-1:0]   quot;

  // raw * 640 = raw * 512 + raw * 128
  assign num     = (TempNumW'(raw_i) << 9) + (TempNumW'(raw_i) << 7) - TempBias;
  assign num_neg = ~num + TempNumW'(1);
  assign neg     = num[TempNumW-1];
  assign mag     = (neg ? num_neg[TempMagW-1:0] : num[TempMagW-1:0]) + TempHalf;
  assign prod    = TProdW'(mag) * TProdW'(TempRecip);
  assign quot    = prod[TempShift+TempQW-1:TempShift];
  assign temp_o  = neg ? TempW'(0) - {1'b0, quot} : {1'b0, quot};

endmodule

FILE: rtl/magnetometer_raw_to_physical.sv
// Magnetometer raw-to-physical conversion, top level.
// A transaction taken into the input register passes on to the result register before it is offered on the output.
// Throughput: one sample set per cycle while out_stall_i does not hold the result register.
// Reset: rst_ni asynchronous active low; empties both stages, loads register defaults.
// Configuration port is always ready; writes to indexes beyond the list are dropped.
// Depends on mrp_pkg, mrp_axis and mrp_temp.
module magnetometer_raw_to_physical (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mrp_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [mrp_pkg::CfgDataW-1:0]       cfg_data_i,
  // raw sample set
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [mrp_pkg::RawW-1:0]           raw_temp_i,
  input  logic [mrp_pkg::RawW-1:0]           raw_x_i,
  input  logic [mrp_pkg::RawW-1:0]           raw_y_i,
  input  logic [mrp_pkg::RawW-1:0]           raw_z_i,
  // physical result
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [mrp_pkg::FieldW-1:0]  field_x_o,
  output logic signed [mrp_pkg::FieldW-1:0]  field_y_o,
  output logic signed [mrp_pkg::FieldW-1:0]  field_z_o,
  output logic signed [mrp_pkg::TempW-1:0]   temperature_o
);
  import mrp_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [2:0] gain_q;
  logic [3:0] hall_q;
  logic [1:0] res_x_q;
  logic [1:0] res_y_q;
  logic [1:0] res_z_q;
  logic       comp_q;
  logic       cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= 3'd7;
      hall_q  <= 4'd0;
      res_x_q <= 2'd0;
      res_y_q <= 2'd0;
      res_z_q <= 2'd0;
      comp_q  <= 1'b0;
    end else if (cfg_we) begin
      // narrower registers keep only the low bits of the write data
      case (cfg_idx_e'(cfg_index_i))
        CfgGain:     gain_q  <= cfg_data_i[2:0];
        CfgHall:     hall_q  <= cfg_data_i[3:0];
        CfgResX:     res_x_q <= cfg_data_i[1:0];
        CfgResY:     res_y_q <= cfg_data_i[1:0];
        CfgResZ:     res_z_q <= cfg_data_i[1:0];
        CfgTempComp: comp_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds the result register. The input stage
  // only stalls when it is full and the result register cannot move on.
  // ---------------------------------------------------------------------------
  logic            in_valid_q;
  logic            out_valid_q;
  logic            in_take;
  logic            out_adv;
  logic [RawW-1:0] raw_temp_q;
  logic [RawW-1:0] raw_x_q;
  logic [RawW-1:0] raw_y_q;
  logic [RawW-1:0] raw_z_q;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (out_adv) begin
        in_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      raw_temp_q <= raw_temp_i;
      raw_x_q    <= raw_x_i;
      raw_y_q    <= raw_y_i;
      raw_z_q    <= raw_z_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Conversion datapath, one multiply per channel
  // ---------------------------------------------------------------------------
  axis_cfg_t cfg_x;
  axis_cfg_t cfg_y;
  axis_cfg_t cfg_z;
  logic      hall_alt;

  assign hall_alt = (hall_q == HallAlt);

  assign cfg_x = '{is_z: 1'b0, alt: hall_alt, gain: gain_q, res: res_x_q, comp: comp_q};
  assign cfg_y = '{is_z: 1'b0, alt: hall_alt, gain: gain_q, res: res_y_q, comp: comp_q};
  assign cfg_z = '{is_z: 1'b1, alt: hall_alt, gain: gain_q, res: res_z_q, comp: comp_q};

  logic signed [FieldW-1:0] field_x_d;
  logic signed [FieldW-1:0] field_y_d;
  logic signed [FieldW-1:0] field_z_d;
  logic signed [TempW-1:0]  temp_d;

  mrp_axis u_axis_x (.raw_i(raw_x_q), .cfg_i(cfg_x), .field_o(field_x_d));
  mrp_axis u_axis_y (.raw_i(raw_y_q), .cfg_i(cfg_y), .field_o(field_y_d));
  mrp_axis u_axis_z (.raw_i(raw_z_q), .cfg_i(cfg_z), .field_o(field_z_d));
  mrp_temp u_temp   (.raw_i(raw_temp_q), .temp_o(temp_d));

  // ---------------------------------------------------------------------------
  // Result register, held while the downstream stalls
  // ---------------------------------------------------------------------------
  logic signed [FieldW-1:0] field_x_q;
  logic signed [FieldW-1:0] field_y_q;
  logic signed [FieldW-1:0] field_z_q;
  logic signed [TempW-1:0]  temp_q;

  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      field_x_q <= field_x_d;
      field_y_q <= field_y_d;
      field_z_q <= field_z_d;
      temp_q    <= temp_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign field_x_o     = field_x_q;
  assign field_y_o     = field_y_q;
  assign field_z_o     = field_z_q;
  assign temperature_o = temp_q;

endmodule
